// ===== sv/ftdfr_pkg.sv =====
// Shared constants, types and codes for the force/torque packet deframer.
`default_nettype none

package ftdfr_pkg;

  // Packet layout
  localparam int unsigned PACKET_BYTES = 25;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned HEADER_BYTES = 2;
  localparam int unsigned FIELD_FIRST  = 4;
  localparam int unsigned FIELD_COUNT  = 6;
  localparam int unsigned FIELD_BYTES  = 3;
  localparam int unsigned FIELD_END    = FIELD_FIRST + FIELD_BYTES * FIELD_COUNT;
  localparam int unsigned FORCE_FIELDS = 3;
  localparam int unsigned FIELD_IDX_W  = 3;

  localparam logic [7:0] SYNC_FIRST  = 8'h00;
  localparam logic [7:0] SYNC_SECOND = 8'h17;

  // Datapath widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned RAW_W  = 24;
  localparam int unsigned GAIN_W = 32;
  localparam int unsigned PROD_W = 56;
  localparam int unsigned SKIP_W = 16;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_GAIN = 2'd1;
  localparam logic [GAIN_W-1:0] FORCE_GAIN_RST  = 32'd4294967;
  localparam logic [GAIN_W-1:0] TORQUE_GAIN_RST = 32'd42950;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_PACKET = 2'd2
  } frame_phase_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_MUL   = 2'd1,
    BK_DRAIN = 2'd2,
    BK_DONE  = 2'd3
  } back_state_e;

  // One deframed packet as handed from the front to the back
  typedef struct packed {
    logic [FIELD_COUNT-1:0][RAW_W-1:0] raw;
    logic [SKIP_W-1:0]                 skip;
  } packet_t;

endpackage

`default_nettype wire

// ===== sv/ftdfr_front.sv =====
// Header hunt, byte counting and raw field capture for the packet deframer.
`default_nettype none

module ftdfr_front import ftdfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output packet_t           q_data_o
);

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HDR   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(FIELD_FIRST);
  localparam logic [POS_W-1:0] POS_END   = POS_W'(FIELD_END);
  localparam logic [1:0]       DIGIT_LAST = 2'(FIELD_BYTES - 1);

  frame_phase_e           phase_q, phase_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [1:0]             digit_q, digit_d;
  logic [FIELD_IDX_W-1:0] field_q, field_d;
  logic [SKIP_W-1:0]      skip_q, skip_d;
  logic [15:0]            asm_q, asm_d;
  logic [RAW_W-1:0]       cap_q [FIELD_COUNT];

  logic              accept;
  logic              at_last;
  logic              cap_we;
  logic              skip_clr;
  logic [1:0]        skip_inc;
  logic [SKIP_W:0]   skip_sum;
  logic [RAW_W-1:0]  word;

  assign at_last    = (phase_q == PH_PACKET) && (pos_q == POS_LAST);
  assign in_stall_o = at_last && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign word       = {asm_q, rx_byte_i};
  assign q_push_o   = accept && at_last;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    digit_d  = digit_q;
    field_d  = field_q;
    asm_d    = asm_q;
    cap_we   = 1'b0;
    skip_clr = 1'b0;
    skip_inc = 2'd0;
    if (accept) begin
      unique case (phase_q)
        PH_PACKET: begin
          if (pos_q >= POS_FIRST && pos_q < POS_END) begin
            asm_d = word[15:0];
            if (digit_q == DIGIT_LAST) begin
              cap_we  = 1'b1;
              digit_d = 2'd0;
              field_d = field_q + 1'b1;
            end else begin
              digit_d = digit_q + 1'b1;
            end
          end
          if (at_last) begin
            skip_clr = 1'b1;
            phase_d  = PH_HUNT;
            pos_d    = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
        PH_ZERO: begin
          if (rx_byte_i == SYNC_SECOND) begin
            phase_d = PH_PACKET;
            pos_d   = POS_HDR;
            digit_d = 2'd0;
            field_d = '0;
          end else if (rx_byte_i == SYNC_FIRST) begin
            skip_inc = 2'd1;
          end else begin
            skip_inc = 2'd2;
            phase_d  = PH_HUNT;
          end
        end
        default: begin
          // hunting, and the unused phase code
          if (rx_byte_i == SYNC_FIRST) begin
            phase_d = PH_ZERO;
          end else begin
            skip_inc = 2'd1;
            phase_d  = PH_HUNT;
          end
        end
      endcase
    end
    skip_sum = {1'b0, skip_q} + (SKIP_W + 1)'(skip_inc);
    skip_d   = skip_sum[SKIP_W] ? '1 : skip_sum[SKIP_W-1:0];
    if (skip_clr) begin
      skip_d = '0;
    end
  end

  // Bypass the capture of this cycle into the pushed packet
  always_comb begin
    for (int i = 0; i < FIELD_COUNT; i++) begin
      q_data_o.raw[i] = (cap_we && (field_q == FIELD_IDX_W'(i))) ? word : cap_q[i];
    end
    q_data_o.skip = skip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      digit_q <= '0;
      field_q <= '0;
      skip_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      digit_q <= digit_d;
      field_q <= field_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
    if (cap_we) begin
      cap_q[field_q] <= word;
    end
  end

`ifndef SYNTHESIS
  a_all_fields_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> (field_q == FIELD_IDX_W'(FIELD_COUNT)) ||
                 (cap_we && (field_q == FIELD_IDX_W'(FIELD_COUNT - 1))))
    else $error("packet pushed before all six fields were captured");
  a_end_of_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> (phase_q == PH_HUNT) && (skip_q == '0) && (pos_q == '0))
    else $error("front did not return to hunting after the last byte");
`endif

endmodule

`default_nettype wire

// ===== sv/ftdfr_queue.sv =====
// Two-entry packet queue between the deframing front and the scaling back.
`default_nettype none

module ftdfr_queue import ftdfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  packet_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output packet_t data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  packet_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("packet queue overflow");
`endif

endmodule

`default_nettype wire

// ===== sv/ftdfr_back.sv =====
// Gain scaling of queued packets through one shared multiplier, plus result register.
`default_nettype none

module ftdfr_back import ftdfr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  packet_t                  q_data_i,
  output logic                     q_pop_o,
  input  logic [GAIN_W-1:0]        force_gain_i,
  input  logic [GAIN_W-1:0]        torque_gain_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PROD_W-1:0] force_x_o,
  output logic signed [PROD_W-1:0] force_y_o,
  output logic signed [PROD_W-1:0] force_z_o,
  output logic signed [PROD_W-1:0] torque_x_o,
  output logic signed [PROD_W-1:0] torque_y_o,
  output logic signed [PROD_W-1:0] torque_z_o,
  output logic [SKIP_W-1:0]        skipped_bytes_o
);

  localparam int unsigned MUL_W = PROD_W + 1;
  localparam logic [FIELD_IDX_W-1:0] IDX_LAST = FIELD_IDX_W'(FIELD_COUNT - 1);

  back_state_e            state_q, state_d;
  logic [FIELD_IDX_W-1:0] idx_q, idx_d;
  packet_t                work_q;
  logic [PROD_W-1:0]      prod_q;
  logic [FIELD_IDX_W-1:0] prod_idx_q;
  logic                   prod_vld_q;
  logic [PROD_W-1:0]      stage_q [FIELD_COUNT];
  logic signed [PROD_W-1:0] out_q [FIELD_COUNT];
  logic [SKIP_W-1:0]      out_skip_q;
  logic                   out_valid_q;

  logic                    issue;
  logic                    out_load;
  logic [RAW_W-1:0]        mul_raw;
  logic [GAIN_W-1:0]       mul_gain;
  logic signed [RAW_W-1:0] mul_a;
  logic signed [GAIN_W:0]  mul_b;
  logic signed [MUL_W-1:0] mul_p;

  // Signed 24-bit times unsigned 32-bit (as signed 33-bit); the product is exact
  assign mul_raw  = work_q.raw[idx_q];
  assign mul_gain = (idx_q < FIELD_IDX_W'(FORCE_FIELDS)) ? force_gain_i : torque_gain_i;
  assign mul_a    = $signed(mul_raw);
  assign mul_b    = $signed({1'b0, mul_gain});
  assign mul_p    = mul_a * mul_b;

  assign out_load = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    q_pop_o = 1'b0;
    issue   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          idx_d   = '0;
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        issue = 1'b1;
        if (idx_q == IDX_LAST) begin
          state_d = BK_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      BK_DRAIN: begin
        state_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_load) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      prod_vld_q <= issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      work_q <= q_data_i;
    end
    if (issue) begin
      prod_q     <= mul_p[PROD_W-1:0];
      prod_idx_q <= idx_q;
    end
    if (prod_vld_q) begin
      stage_q[prod_idx_q] <= prod_q;
    end
    if (out_load) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        out_q[i] <= $signed(stage_q[i]);
      end
      out_skip_q <= work_q.skip;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign force_x_o       = out_q[0];
  assign force_y_o       = out_q[1];
  assign force_z_o       = out_q[2];
  assign torque_x_o      = out_q[3];
  assign torque_y_o      = out_q[4];
  assign torque_z_o      = out_q[5];
  assign skipped_bytes_o = out_skip_q;

`ifndef SYNTHESIS
  a_drained_before_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DONE) |-> !prod_vld_q)
    else $error("result handed over before the last product was stored");
  a_pop_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == BK_MUL) && (idx_q == '0))
    else $error("popped packet did not start at the first field");
`endif

endmodule

`default_nettype wire

// ===== sv/force_torque_packet_deframer_core.sv =====
// Top level of the force/torque packet deframer: gain registers, front, queue, back.
//
// Input channel: one received byte per beat on rx_byte_i (in_valid_i / in_stall_o).
// A beat is taken on every cycle; in_stall_o rises only on the last byte of a packet
// when both queue entries already hold packets that the back has not started.
// The front hunts for the header 0x00 0x17, counts discarded bytes (saturating at
// 65535), and captures the six big-endian 24-bit fields of a 25-byte packet.
// Output channel: one beat per packet (out_valid_o / out_stall_i) carrying six
// signed Q23.32 products and the skipped-byte count. The result sits in an output
// register, so a stalled receiver does not stall the byte stream until the queue
// fills as well.
// After the last packet byte is taken, the back pops the packet, passes the six
// fields one after another through the single shared 24x32 multiplier, drains
// the product register and hands the result over. Throughput: one byte per cycle
// while in_stall_o is low, one packet per 25 bytes.
// Configuration: cfg_index_i 0 writes the force gain, 1 the torque gain; other
// indexes are dropped. cfg_ready_o is always high. Write only while the block is idle.
// Reset: rst_ni clears framing state, the queue and the output valid, and loads
// the default gains; no clearing pass is needed.
`default_nettype none

module force_torque_packet_deframer_core import ftdfr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // byte input
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [BYTE_W-1:0]        rx_byte_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PROD_W-1:0] force_x_o,
  output logic signed [PROD_W-1:0] force_y_o,
  output logic signed [PROD_W-1:0] force_z_o,
  output logic signed [PROD_W-1:0] torque_x_o,
  output logic signed [PROD_W-1:0] torque_y_o,
  output logic signed [PROD_W-1:0] torque_z_o,
  output logic [SKIP_W-1:0]        skipped_bytes_o,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [GAIN_W-1:0]        cfg_data_i
);

  logic [GAIN_W-1:0] force_gain_q, force_gain_d;
  logic [GAIN_W-1:0] torque_gain_q, torque_gain_d;
  logic              cfg_we;

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  packet_t q_wdata;
  packet_t q_rdata;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    force_gain_d  = force_gain_q;
    torque_gain_d = torque_gain_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_FORCE_GAIN:  force_gain_d  = cfg_data_i;
        CFG_TORQUE_GAIN: torque_gain_d = cfg_data_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_gain_q  <= FORCE_GAIN_RST;
      torque_gain_q <= TORQUE_GAIN_RST;
    end else begin
      force_gain_q  <= force_gain_d;
      torque_gain_q <= torque_gain_d;
    end
  end

  // Front: header hunt and field capture, one byte per cycle unless stalled
  ftdfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // Queue: decouple byte intake from scaling and output backpressure
  ftdfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  // Back: scale the six fields and hold the result beat
  ftdfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .force_gain_i    (force_gain_q),
    .torque_gain_i   (torque_gain_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .force_x_o       (force_x_o),
    .force_y_o       (force_y_o),
    .force_z_o       (force_z_o),
    .torque_x_o      (torque_x_o),
    .torque_y_o      (torque_y_o),
    .torque_z_o      (torque_z_o),
    .skipped_bytes_o (skipped_bytes_o)
  );

endmodule

`default_nettype wire

// ===== tb/force_torque_packet_deframer_checker.sv =====
// Scoreboard for the force/torque deframer: tracks framing, predicts readings, compares beats.
module force_torque_packet_deframer_checker import ftdfr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic [BYTE_W-1:0]        rx_byte_i,
  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic signed [PROD_W-1:0] force_x_o,
  input  logic signed [PROD_W-1:0] force_y_o,
  input  logic signed [PROD_W-1:0] force_z_o,
  input  logic signed [PROD_W-1:0] torque_x_o,
  input  logic signed [PROD_W-1:0] torque_y_o,
  input  logic signed [PROD_W-1:0] torque_z_o,
  input  logic [SKIP_W-1:0]        skipped_bytes_o,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [GAIN_W-1:0]        cfg_data_i,
  output int unsigned              readings_due_o,
  output int unsigned              failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FIELD_COUNT-1:0][PROD_W-1:0] value;
    logic [SKIP_W-1:0]                  skip;
  } reading_t;

  localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

  frame_phase_e       phase = PH_HUNT;
  logic [POS_W-1:0]   pos = '0;
  logic [RAW_W-1:0]   shift_word = '0;
  logic [RAW_W-1:0]   captured [FIELD_COUNT];
  logic [SKIP_W-1:0]  skip_count = '0;
  logic [GAIN_W-1:0]  force_gain = FORCE_GAIN_RST;
  logic [GAIN_W-1:0]  torque_gain = TORQUE_GAIN_RST;
  reading_t           due_readings [$];
  int unsigned        failures = 0;

  initial begin
    readings_due_o = 0;
    failures_o = 0;
  end

  function automatic logic [SKIP_W-1:0] skip_plus(input logic [SKIP_W-1:0] cnt,
                                                 input int unsigned n);
    logic [SKIP_W:0] sum;
    sum = (SKIP_W + 1)'(cnt + n);
    return (sum > SKIP_MAX) ? SKIP_MAX : sum[SKIP_W-1:0];
  endfunction

  // Exact product of the sign-extended raw value and the unsigned gain.
  function automatic logic [PROD_W-1:0] scale_reading(input logic [RAW_W-1:0] raw,
                                                     input logic [GAIN_W-1:0] gain);
    logic signed [PROD_W-1:0] v;
    logic signed [PROD_W-1:0] g;
    v = {{(PROD_W-RAW_W){raw[RAW_W-1]}}, raw};
    g = {{(PROD_W-GAIN_W){1'b0}}, gain};
    return v * g;
  endfunction

  task automatic track_frame_byte(input logic [BYTE_W-1:0] b);
    reading_t    r;
    int unsigned rel;
    case (phase)
      PH_PACKET: begin
        if (pos >= FIELD_FIRST && pos < FIELD_END) begin
          rel = pos - FIELD_FIRST;
          shift_word = {shift_word[RAW_W-BYTE_W-1:0], b};
          if (rel % FIELD_BYTES == FIELD_BYTES - 1) captured[rel / FIELD_BYTES] = shift_word;
        end
        if (pos + 1 >= PACKET_BYTES) begin
          for (int i = 0; i < FIELD_COUNT; i++)
            r.value[i] = scale_reading(captured[i], (i < FORCE_FIELDS) ? force_gain
                                                                     : torque_gain);
          r.skip = skip_count;
          due_readings.push_back(r);
          skip_count = '0;
          phase = PH_HUNT;
          pos = '0;
          shift_word = '0;
        end else begin
          pos = pos + 1'b1;
        end
      end
      PH_ZERO: begin
        if (b == SYNC_SECOND) begin
          phase = PH_PACKET;
          pos = POS_W'(HEADER_BYTES);
          shift_word = '0;
        end else if (b == SYNC_FIRST) begin
          skip_count = skip_plus(skip_count, 1);
        end else begin
          skip_count = skip_plus(skip_count, 2);
          phase = PH_HUNT;
        end
      end
      default: begin
        if (b == SYNC_FIRST) begin
          phase = PH_ZERO;
        end else begin
          skip_count = skip_plus(skip_count, 1);
          phase = PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    reading_t got;
    if (!rst_ni) begin
      phase = PH_HUNT;
      pos = '0;
      shift_word = '0;
      skip_count = '0;
      force_gain = FORCE_GAIN_RST;
      torque_gain = TORQUE_GAIN_RST;
      due_readings.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FORCE_GAIN:  force_gain = cfg_data_i;
          CFG_TORQUE_GAIN: torque_gain = cfg_data_i;
          default: ;
        endcase
      end
      // compare before taking this edge's byte: a reading never leaves on its own last byte
      if (out_valid_o && !out_stall_i) begin
        got.value = {torque_z_o, torque_y_o, torque_x_o, force_z_o, force_y_o, force_x_o};
        got.skip  = skipped_bytes_o;
        if (due_readings.size() == 0) begin
          if (failures < 10)
            $display("[%0t] reading beat with none due: f %h %h %h t %h %h %h skip %0d",
                     $time, got.value[0], got.value[1], got.value[2],
                     got.value[3], got.value[4], got.value[5], got.skip);
          failures++;
        end else begin
          want = due_readings.pop_front();
          if (got !== want) begin
            if (failures < 10) begin
              $display("[%0t] reading mismatch", $time);
              $display("  expected f %h %h %h t %h %h %h skip %0d",
                       want.value[0], want.value[1], want.value[2],
                       want.value[3], want.value[4], want.value[5], want.skip);
              $display("  actual   f %h %h %h t %h %h %h skip %0d",
                       got.value[0], got.value[1], got.value[2],
                       got.value[3], got.value[4], got.value[5], got.skip);
            end
            failures++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) track_frame_byte(rx_byte_i);
    end
    readings_due_o <= due_readings.size();
    failures_o <= failures;
  end

endmodule

// ===== tb/force_torque_packet_deframer_core_tb.sv =====
// Stimulus and verdict for the force/torque packet deframer core.
module force_torque_packet_deframer_core_tb import ftdfr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned SETTLE       = 16;     // covers the back-end latency
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned LONG_NOISE   = 40;     // one long hunting stretch
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // register indexes the block has to drop
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [BYTE_W-1:0]        rx_byte = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [PROD_W-1:0] force_x, force_y, force_z;
  logic signed [PROD_W-1:0] torque_x, torque_y, torque_z;
  logic [SKIP_W-1:0]        skipped_bytes;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [GAIN_W-1:0]        cfg_data = '0;

  int unsigned readings_due;
  int unsigned failures;

  // sender pacing
  int unsigned       burst_left = 0;
  bit                steady_sender = 1'b0;
  logic [BYTE_W-1:0] last_sent = 8'hFF;

  // receiver pacing
  rx_mode_e    rx_mode = RX_FREE;
  logic [31:0] rx_tick = '0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;

  int unsigned cycle_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  force_torque_packet_deframer_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .force_x_o      (force_x),
    .force_y_o      (force_y),
    .force_z_o      (force_z),
    .torque_x_o     (torque_x),
    .torque_y_o     (torque_y),
    .torque_z_o     (torque_z),
    .skipped_bytes_o(skipped_bytes),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  force_torque_packet_deframer_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .force_x_o      (force_x),
    .force_y_o      (force_y),
    .force_z_o      (force_z),
    .torque_x_o     (torque_x),
    .torque_y_o     (torque_y),
    .torque_z_o     (torque_z),
    .skipped_bytes_o(skipped_bytes),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .readings_due_o (readings_due),
    .failures_o     (failures)
  );

  // Receiver: switch between random stall patterns. A toggle of hold_req starts one
  // long hold-off, so the output register and the queue fill and the block has to
  // stall its byte input on a packet's last byte.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 96 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte and hold it until the beat is taken. Between bursts drop valid
  // for a random gap, unless the sender is in a steady stretch.
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady_sender && $urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    last_sent = b;
  endtask

  // Hunting bytes: zero-heavy so held zeros get both the zero and the other-byte
  // follow-up; never complete a header.
  task automatic send_noise(input int unsigned n);
    logic [BYTE_W-1:0] b;
    repeat (n) begin
      b = ($urandom_range(0, 3) == 0) ? SYNC_FIRST : BYTE_W'($urandom);
      if (last_sent == SYNC_FIRST && b == SYNC_SECOND) b = b + 1'b1;
      push_byte(b);
    end
  endtask

  // One packet: header, then six big-endian 24-bit fields in the payload. With
  // mimic set, the spare bytes look like headers, which the block must swallow.
  task automatic send_packet(input logic [FIELD_COUNT-1:0][RAW_W-1:0] fields,
                             input bit mimic);
    logic [BYTE_W-1:0] b;
    int unsigned       rel;
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    for (int unsigned p = HEADER_BYTES; p < PACKET_BYTES; p++) begin
      if (p >= FIELD_FIRST && p < FIELD_END) begin
        rel = p - FIELD_FIRST;
        b = BYTE_W'(fields[rel / FIELD_BYTES] >>
                    (BYTE_W * (FIELD_BYTES - 1 - rel % FIELD_BYTES)));
      end else if (mimic) begin
        b = (p % 2 == 1) ? SYNC_SECOND : SYNC_FIRST;
      end else begin
        b = BYTE_W'($urandom);
      end
      push_byte(b);
    end
  endtask

  function automatic logic [FIELD_COUNT-1:0][RAW_W-1:0] random_fields(input bit wild);
    logic [FIELD_COUNT-1:0][RAW_W-1:0] f;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (!wild) f[i] = RAW_W'($urandom);
      else begin
        case ($urandom_range(0, 4))
          0:       f[i] = 24'h800000;
          1:       f[i] = 24'h7FFFFF;
          2:       f[i] = 24'h000000;
          3:       f[i] = 24'hFFFFFF;
          default: f[i] = RAW_W'($urandom);
        endcase
      end
    end
    return f;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 3))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait until every reading has left, then let the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both gains back to back, then a write to an index the block must drop.
  task automatic program_gains(input logic [GAIN_W-1:0] f_gain,
                               input logic [GAIN_W-1:0] t_gain);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FORCE_GAIN;
    cfg_data  <= f_gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TORQUE_GAIN;
    cfg_data  <= t_gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_data  <= $urandom;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset gains: a plain discard, a held zero followed by another
    // byte, a held zero followed by a zero, then a packet with field extremes and
    // header look-alikes inside it.
    push_byte(8'hFF);
    push_byte(SYNC_FIRST);
    push_byte(8'h55);
    push_byte(SYNC_FIRST);
    send_packet({24'h123456, 24'h000001, 24'hFFFFFF, 24'h000000, 24'h7FFFFF, 24'h800000},
                1'b1);
    drain();

    // Gain extremes.
    program_gains('1, '1);
    repeat (4) begin
      send_noise($urandom_range(0, 3));
      send_packet(random_fields(1'b1), 1'b0);
    end
    drain();
    program_gains('0, '0);
    repeat (3) send_packet(random_fields(1'b1), 1'b0);
    drain();
    program_gains(32'd1, 32'h8000_0000);
    repeat (3) send_packet(random_fields(1'b1), 1'b0);
    drain();

    // One long hunting stretch at full rate, then packets back to back.
    program_gains(random_gain(), random_gain());
    steady_sender = 1'b1;
    send_noise(LONG_NOISE);
    send_packet(random_fields(1'b0), 1'b0);
    send_packet(random_fields(1'b0), 1'b0);
    drain();

    // Long receiver hold-off while the sender keeps streaming packets back to back.
    hold_req <= ~hold_req;
    repeat (8) send_packet(random_fields(1'b0), 1'b0);
    drain();
    steady_sender = 1'b0;

    // Random traffic: mostly well-formed packets, short noise between them, the
    // odd long run of garbage; new gains every four packets.
    for (int k = 0; k < 12; k++) begin
      if (k % 4 == 3) begin
        drain();
        program_gains(random_gain(), random_gain());
        steady_sender = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 5) == 0) send_noise($urandom_range(10, 40));
      else send_noise($urandom_range(0, 2));
      send_packet(random_fields($urandom_range(0, 3) == 0), $urandom_range(0, 7) == 0);
    end
    drain();

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
